/* src/fba_pkg.sv */
// Shared types and constants for the fit block allocator.
// Used by fba_ctrl, fba_datapath and fit_block_allocator_core; no dependencies.
`default_nettype none

package fba_pkg;

   // Fit policy codes held in the fit_mode register
   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_BEST  = 2'd1;
   localparam logic [1:0] MODE_WORST = 2'd2;

   // Register indexes on the csr write channel
   localparam logic CSR_FIT_MODE      = 1'b0;
   localparam logic CSR_BLOCKS_IN_USE = 1'b1;

   // Request action codes
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_ALLOC = 1'b1;

   // Field widths of the ports
   localparam int CSR_DATA_BITS = 7;
   localparam int SLOT_BITS     = 6;
   localparam int AMOUNT_BITS   = 16;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } fba_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;        // write a block size, clear its mark
      logic alloc_init;  // latch request, reset scan and best choice
      logic issue;       // read the next table entry
      logic commit;      // mark the chosen block, present the result
   } fba_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic count_zero;  // no entries take part in the scan
      logic scan_last;   // entry being read is the last one
   } fba_status_type;

endpackage

`default_nettype wire

/* src/fba_ctrl.sv */
// Controller state machine for the fit block allocator.
// Depends on fba_pkg; drives the command struct for fba_datapath.
`default_nettype none

module fba_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  req_action,
   input  wire fba_pkg::fba_status_type status,
   output fba_pkg::fba_cmd_type       cmd,
   output logic                       busy
);

   fba_pkg::fba_state_type state_ff;
   fba_pkg::fba_state_type state_in;

   logic take_req;

   assign take_req = start && (state_ff == fba_pkg::ST_IDLE);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fba_pkg::ST_IDLE: begin
            if (start && (req_action == fba_pkg::ACT_ALLOC)) begin
               state_in = status.count_zero ? fba_pkg::ST_FINISH : fba_pkg::ST_SCAN;
            end
         end
         fba_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = fba_pkg::ST_DRAIN;
            end
         end
         fba_pkg::ST_DRAIN: begin
            state_in = fba_pkg::ST_FINISH;
         end
         fba_pkg::ST_FINISH: begin
            state_in = fba_pkg::ST_IDLE;
         end
         default: begin
            state_in = fba_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd.load       = take_req && (req_action == fba_pkg::ACT_LOAD);
      cmd.alloc_init = take_req && (req_action == fba_pkg::ACT_ALLOC);
      cmd.issue      = (state_ff == fba_pkg::ST_SCAN);
      cmd.commit     = (state_ff == fba_pkg::ST_FINISH);
      busy           = (state_ff != fba_pkg::ST_IDLE);
   end

   // Checks
   a_finish_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fba_pkg::ST_FINISH) |=> (state_ff == fba_pkg::ST_IDLE))
      else $error("commit not followed by idle");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy && !cmd.issue && !cmd.commit)
      else $error("load issued while busy");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && status.scan_last) |=> (state_ff == fba_pkg::ST_DRAIN))
      else $error("scan ran past its last entry");

endmodule

`default_nettype wire

/* src/fba_datapath.sv */
// Datapath for the fit block allocator: size table, used marks, scan and choice.
// Depends on fba_pkg; driven by the command struct from fba_ctrl.
`default_nettype none

module fba_datapath #(
   parameter int NUM_BLOCKS = 64,
   parameter int SIZE_BITS  = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire fba_pkg::fba_cmd_type                 cmd,
   output fba_pkg::fba_status_type                   status,
   input  wire logic [fba_pkg::SLOT_BITS-1:0]        req_slot,
   input  wire logic [fba_pkg::AMOUNT_BITS-1:0]      req_amount,
   input  wire logic                                 csr_write,
   input  wire logic                                 csr_index,
   input  wire logic [fba_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output logic                                      rsp_strobe,
   output logic                                      rsp_found,
   output logic [fba_pkg::SLOT_BITS-1:0]             rsp_chosen_block,
   output logic [fba_pkg::AMOUNT_BITS-1:0]           rsp_leftover
);

   localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CW = $clog2(NUM_BLOCKS + 1);

   // Configuration registers
   logic [1:0]                          fit_mode_ff;
   logic [fba_pkg::CSR_DATA_BITS-1:0]   blocks_in_use_ff;

   // Storage
   logic [SIZE_BITS-1:0] size_mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] used_ff;

   // Scan control
   logic [SIZE_BITS-1:0] amount_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        cnt_ff;
   logic [AW-1:0]        addr;

   // Read stage
   logic                 rd_valid_ff;
   logic [SIZE_BITS-1:0] rd_data_ff;
   logic                 rd_used_ff;
   logic [AW-1:0]        rd_idx_ff;

   // Best choice so far
   logic                 have_ff;
   logic [AW-1:0]        best_idx_ff;
   logic [SIZE_BITS-1:0] best_left_ff;

   // Result registers
   logic                               rsp_strobe_ff;
   logic                               rsp_found_ff;
   logic [fba_pkg::SLOT_BITS-1:0]      rsp_chosen_ff;
   logic [fba_pkg::AMOUNT_BITS-1:0]    rsp_left_ff;

   logic                 slot_ok;
   logic [AW-1:0]        waddr;
   logic [CW-1:0]        count_sat;
   logic                 fits;
   logic [SIZE_BITS-1:0] left;
   logic                 take;

   assign slot_ok = (32'(req_slot) < 32'(NUM_BLOCKS));
   assign waddr   = AW'(req_slot);
   assign addr    = cnt_ff[AW-1:0];

   // Entries in the scan, saturated to the table depth
   assign count_sat = (32'(blocks_in_use_ff) > 32'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                                : CW'(blocks_in_use_ff);

   assign status.count_zero = (blocks_in_use_ff == '0);
   assign status.scan_last  = ((cnt_ff + CW'(1)) == count_ff);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff      <= fba_pkg::MODE_FIRST;
         blocks_in_use_ff <= fba_pkg::CSR_DATA_BITS'(64);
      end else if (csr_write) begin
         unique case (csr_index)
            fba_pkg::CSR_FIT_MODE:      fit_mode_ff      <= csr_wdata[1:0];
            fba_pkg::CSR_BLOCKS_IN_USE: blocks_in_use_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Size table: written by loads, read once per scan step
   always_ff @(posedge clock) begin
      if (cmd.load && slot_ok) begin
         size_mem[waddr] <= SIZE_BITS'(req_amount);
      end
      rd_data_ff <= size_mem[addr];
   end

   // Used marks: cleared by a load, set by a commit that found a block
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.load && slot_ok) begin
         used_ff[waddr] <= 1'b0;
      end else if (cmd.commit && have_ff) begin
         used_ff[best_idx_ff] <= 1'b1;
      end
   end

   // Scan counter and request latch
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.alloc_init) begin
         cnt_ff <= '0;
      end else if (cmd.issue) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (cmd.alloc_init) begin
         amount_ff <= SIZE_BITS'(req_amount);
         count_ff  <= count_sat;
      end
   end

   // Read stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.issue;
      end
      rd_used_ff <= used_ff[addr];
      rd_idx_ff  <= addr;
   end

   // Compare the entry just read against the best so far
   always_comb begin
      fits = !rd_used_ff && (rd_data_ff >= amount_ff);
      left = rd_data_ff - amount_ff;
      take = 1'b0;
      if (fits) begin
         if (!have_ff) begin
            take = 1'b1;
         end else if (fit_mode_ff == fba_pkg::MODE_BEST) begin
            take = (left < best_left_ff);
         end else if (fit_mode_ff == fba_pkg::MODE_WORST) begin
            take = (left > best_left_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (cmd.alloc_init) begin
         have_ff <= 1'b0;
      end else if (rd_valid_ff && take) begin
         have_ff <= 1'b1;
      end
      if (rd_valid_ff && take) begin
         best_idx_ff  <= rd_idx_ff;
         best_left_ff <= left;
      end
   end

   // Result registers, shown for one cycle after the commit
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.commit;
      end
      if (cmd.commit) begin
         rsp_found_ff  <= have_ff;
         rsp_chosen_ff <= have_ff ? fba_pkg::SLOT_BITS'(best_idx_ff) : '0;
         rsp_left_ff   <= have_ff ? fba_pkg::AMOUNT_BITS'(best_left_ff) : '0;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_chosen_block = rsp_chosen_ff;
   assign rsp_leftover     = rsp_left_ff;

   // Checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for more than one cycle");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_found_ff) |-> (rsp_chosen_ff == '0) && (rsp_left_ff == '0))
      else $error("not-found result carries nonzero fields");

   a_commit_marks: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && have_ff) |=> used_ff[$past(best_idx_ff)])
      else $error("chosen block not marked used");

endmodule

`default_nettype wire

/* src/fit_block_allocator_core.sv */
// Top level of the fit block allocator: controller plus datapath.
// Depends on fba_pkg, fba_ctrl and fba_datapath.
//
//   Channel   Ports                                      Transfer
//   request   start, busy, req_action/slot/amount       start && !busy
//   result    rsp_strobe, rsp_found/chosen_block/leftover  rsp_strobe, one cycle
//   csr       csr_valid, csr_ready, csr_index, csr_wdata   csr_valid && csr_ready
//
// A load transfer leaves busy low.
// An allocate scans N = min(blocks_in_use, NUM_BLOCKS) entries, one per cycle
// through the size table's single read port: busy stays high through the scan,
// drain and finish states, and the result strobe is registered from the commit.
// With N = 0 the scan and drain are skipped: busy is high in the finish state
// only, and the strobe is again registered from the commit.
// Reset clears the used marks, the controller and the strobe, and sets first fit with blocks_in_use at 64.
// The result cannot be stalled; csr_ready is low while an allocate is in progress.
`default_nettype none

module fit_block_allocator_core #(
   parameter int NUM_BLOCKS = 64,
   parameter int SIZE_BITS  = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_action,
   input  wire logic [fba_pkg::SLOT_BITS-1:0]        req_slot,
   input  wire logic [fba_pkg::AMOUNT_BITS-1:0]      req_amount,
   output logic                                      rsp_strobe,
   output logic                                      rsp_found,
   output logic [fba_pkg::SLOT_BITS-1:0]             rsp_chosen_block,
   output logic [fba_pkg::AMOUNT_BITS-1:0]           rsp_leftover,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic                                 csr_index,
   input  wire logic [fba_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   fba_pkg::fba_cmd_type    cmd;
   fba_pkg::fba_status_type status;
   logic                    csr_write;

   assign csr_ready = !busy;
   assign csr_write = csr_valid && csr_ready;

   fba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   fba_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_slot         (req_slot),
      .req_amount       (req_amount),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_found        (rsp_found),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_leftover     (rsp_leftover)
   );

endmodule

`default_nettype wire
